// ===== rtl/cma_pkg.sv =====
// Shared types and constants for the centered moving average block.
// Used by the controller, the datapath and the top level; no dependencies.
package cma_pkg;

  // Default configuration of the top-level parameters.
  localparam int unsigned MaxHalfWindowDef = 7;
  localparam int unsigned SampleBitsDef    = 24;

  // Half-window register: width and value after reset.
  localparam int unsigned HwBits  = 3;
  localparam logic [HwBits-1:0] HwReset = 3'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic shift;     // push the accepted sample into the window store
    logic start;     // clear the accumulator and the read index
    logic acc;       // add the indexed store entry to the accumulator
    logic load_div;  // load the divider from the finished sum
    logic div_step;  // one restoring division step
    logic load_out;  // move the quotient into the output register
    logic last;      // last-result flag that goes with load_out
  } cma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_last;  // the current add is the final one of the window
    logic div_last;  // the current division step is the final one
  } cma_status_t;

endpackage

// ===== rtl/cma_datapath.sv =====
// Datapath of the centered moving average: window store, accumulator,
// bit-serial divider and output register. Depends on cma_pkg.
module cma_datapath #(
  parameter int unsigned MAX_HALF_WINDOW = cma_pkg::MaxHalfWindowDef,
  parameter int unsigned SAMPLE_BITS     = cma_pkg::SampleBitsDef,
  localparam int unsigned Depth  = 2 * MAX_HALF_WINDOW + 1,
  localparam int unsigned CntW   = $clog2(Depth + 1)
) (
  input  logic                     clk_i,
  input  cma_pkg::cma_cmd_t        cmd_i,
  input  logic [CntW-1:0]          cnt_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output cma_pkg::cma_status_t     status_o,
  output logic [SAMPLE_BITS-1:0]   result_o,
  output logic                     result_last_o
);
  import cma_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned ExtW = $clog2(Depth);
  localparam int unsigned SumW = SAMPLE_BITS + ExtW;
  localparam int unsigned BitW = $clog2(SAMPLE_BITS);

  logic [SAMPLE_BITS-1:0] store_q [Depth];
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [SumW-1:0]        acc_q, acc_d, sum_next;
  logic [CntW-1:0]        rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] dq_q, dq_d;
  logic [BitW-1:0]        bit_q, bit_d;
  logic [SAMPLE_BITS-1:0] out_q;
  logic                   out_last_q;
  logic [CntW:0]          trial;
  logic                   trial_ge;

  // Running sum with the entry under the read index added.
  assign sum_next = acc_q + SumW'(store_q[idx_q]);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial    = {rem_q, dq_q[SAMPLE_BITS-1]};
  assign trial_ge = (trial >= {1'b0, cnt_i});

  assign status_o.sum_last = (idx_q == IdxW'(cnt_i - 1'b1));
  assign status_o.div_last = (bit_q == '0);

  // Next values of the accumulator and divider registers.
  always_comb begin
    idx_d = idx_q;
    acc_d = acc_q;
    rem_d = rem_q;
    dq_d  = dq_q;
    bit_d = bit_q;
    if (cmd_i.start) begin
      idx_d = '0;
      acc_d = '0;
    end else if (cmd_i.acc) begin
      idx_d = idx_q + 1'b1;
      acc_d = sum_next;
    end
    if (cmd_i.load_div) begin
      // The sum is below cnt * 2^SAMPLE_BITS, so its upper part is below cnt.
      rem_d = CntW'(sum_next[SumW-1:SAMPLE_BITS]);
      dq_d  = sum_next[SAMPLE_BITS-1:0];
      bit_d = BitW'(SAMPLE_BITS - 1);
    end else if (cmd_i.div_step) begin
      rem_d = trial_ge ? CntW'(trial - {1'b0, cnt_i}) : trial[CntW-1:0];
      dq_d  = {dq_q[SAMPLE_BITS-2:0], trial_ge};
      bit_d = bit_q - 1'b1;
    end
  end

  // Window store: entry 0 holds the newest sample.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      store_q[0] <= sample_i;
      for (int i = 1; i < Depth; i++) begin
        store_q[i] <= store_q[i-1];
      end
    end
  end

  // Arithmetic and output registers carry payload only.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    dq_q  <= dq_d;
    bit_q <= bit_d;
    if (cmd_i.load_out) begin
      out_q      <= dq_q;
      out_last_q <= cmd_i.last;
    end
  end

  assign result_o      = out_q;
  assign result_last_o = out_last_q;

endmodule

// ===== rtl/cma_controller.sv =====
// Controller of the centered moving average: block counters, half-window
// register, result sequencing and output handshake. Depends on cma_pkg.
module cma_controller #(
  parameter int unsigned MAX_HALF_WINDOW = cma_pkg::MaxHalfWindowDef,
  localparam int unsigned Depth = 2 * MAX_HALF_WINDOW + 1,
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cma_pkg::HwBits-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  cma_pkg::cma_status_t        status_i,
  output cma_pkg::cma_cmd_t           cmd_o,
  output logic [CntW-1:0]             cnt_o
);
  import cma_pkg::*;

  localparam int unsigned PendW = $clog2(MAX_HALF_WINDOW + 2);

  typedef enum logic [1:0] {
    StIdle,
    StSum,
    StDiv,
    StWrite
  } state_e;

  state_e            state_q, state_d;
  logic [HwBits-1:0] hw_q, hw_d;
  logic [CntW-1:0]   rcv_q, rcv_d, rcv_inc;
  logic [PendW-1:0]  pend_q, pend_d;
  logic [PendW-1:0]  left_q, left_d;
  logic              flush_q, flush_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [PendW-1:0]  h;
  logic [CntW-1:0]   win_len;
  logic [CntW-1:0]   flush_cnt_first, flush_cnt_next;
  logic              out_free;

  // Effective half window, clamped to what the store can hold.
  assign h = (32'(hw_q) > 32'(MAX_HALF_WINDOW)) ? PendW'(MAX_HALF_WINDOW) : PendW'(hw_q);
  assign win_len = CntW'({h, 1'b1});
  assign rcv_inc = (rcv_q < win_len) ? rcv_q + 1'b1 : rcv_q;

  // Window sizes during a flush are clipped to the samples of the block.
  always_comb begin
    logic [CntW-1:0] span_first;
    logic [CntW-1:0] span_next;
    span_first      = CntW'(pend_q) + CntW'(1) + CntW'(h);
    span_next       = CntW'(left_q) - CntW'(1) + CntW'(h);
    flush_cnt_first = (span_first > rcv_inc) ? rcv_inc : span_first;
    flush_cnt_next  = (span_next > rcv_q) ? rcv_q : span_next;
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next-state and command logic.
  always_comb begin
    state_d     = state_q;
    hw_d        = hw_q;
    rcv_d       = rcv_q;
    pend_d      = pend_q;
    left_d      = left_q;
    flush_d     = flush_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.shift = 1'b1;
          rcv_d       = rcv_inc;
          if (!in_last_i) begin
            if (pend_q < h) begin
              pend_d = pend_q + 1'b1;
            end else begin
              flush_d     = 1'b0;
              left_d      = PendW'(1);
              cnt_d       = rcv_inc;
              cmd_o.start = 1'b1;
              state_d     = StSum;
            end
          end else begin
            flush_d     = 1'b1;
            left_d      = pend_q + 1'b1;
            cnt_d       = flush_cnt_first;
            cmd_o.start = 1'b1;
            state_d     = StSum;
          end
        end
      end
      StSum: begin
        cmd_o.acc = 1'b1;
        if (status_i.sum_last) begin
          cmd_o.load_div = 1'b1;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.last     = flush_q && (left_q == PendW'(1));
          out_valid_d    = 1'b1;
          if (flush_q && (left_q > PendW'(1))) begin
            left_d      = left_q - 1'b1;
            cnt_d       = flush_cnt_next;
            cmd_o.start = 1'b1;
            state_d     = StSum;
          end else begin
            if (flush_q) begin
              rcv_d  = '0;
              pend_d = '0;
            end
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    // A register write opens a new block.
    if (cfg_we_i) begin
      hw_d   = cfg_wdata_i;
      rcv_d  = '0;
      pend_d = '0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hw_q        <= HwReset;
      rcv_q       <= '0;
      pend_q      <= '0;
      left_q      <= '0;
      flush_q     <= 1'b0;
      cnt_q       <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      rcv_q       <= rcv_d;
      pend_q      <= pend_d;
      left_q      <= left_d;
      flush_q     <= flush_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign cnt_o       = cnt_q;

endmodule

// ===== rtl/centered_moving_average.sv =====
// Top level of the centered moving average filter over sample blocks.
// Instantiates cma_controller and cma_datapath; depends on cma_pkg.
//
//   Channel   Direction  Request holds
//   s_axis    in         tdata: sample; tlast: block_end
//   m_axis    out        tdata: filtered_value; tlast: last_result
//   cfg       in         cfg_wdata_i: half_window, written when cfg_we_i is high
//
// A sample that owes no result is taken without leaving the idle state. Each
// result is computed in order: the accumulator adds up the n window samples,
// the restoring divider produces one quotient bit per cycle, and one write
// moves the quotient into the output register. The last sample of a block
// flushes up to half_window + 1 results back to back. The output register
// lets the next sample in while a result waits; a stalled output stops only
// the next write-back. Reset clears the counters and sets half_window to 1.
module centered_moving_average #(
  parameter int unsigned MAX_HALF_WINDOW = cma_pkg::MaxHalfWindowDef,
  parameter int unsigned SAMPLE_BITS     = cma_pkg::SampleBitsDef,
  localparam int unsigned TdataW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cma_pkg::HwBits-1:0]  cfg_wdata_i,    // half_window
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [TdataW-1:0]           s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [TdataW-1:0]           m_axis_tdata,   // [SAMPLE_BITS-1:0] filtered_value
  output logic                        m_axis_tlast
);
  import cma_pkg::*;

  localparam int unsigned Depth = 2 * MAX_HALF_WINDOW + 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cma_cmd_t               cmd;
  cma_status_t            status;
  logic [CntW-1:0]        cnt;
  logic [SAMPLE_BITS-1:0] result;

  cma_controller #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd),
    .cnt_o       (cnt)
  );

  cma_datapath #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .cnt_i         (cnt),
    .sample_i      (s_axis_tdata[SAMPLE_BITS-1:0]),
    .status_o      (status),
    .result_o      (result),
    .result_last_o (m_axis_tlast)
  );

  // Zero padding up to whole bytes.
  assign m_axis_tdata = TdataW'(result);

endmodule

// ===== rtl/cma_checker.sv =====
// Port-level checks for the centered moving average top level.
// Bound to centered_moving_average; depends on cma_pkg.
module cma_checker #(
  parameter int unsigned MAX_HALF_WINDOW = cma_pkg::MaxHalfWindowDef,
  parameter int unsigned SAMPLE_BITS     = cma_pkg::SampleBitsDef,
  localparam int unsigned TdataW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [cma_pkg::HwBits-1:0]  cfg_wdata_i,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [TdataW-1:0]           s_axis_tdata,
  input logic                        s_axis_tlast,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [TdataW-1:0]           m_axis_tdata,
  input logic                        m_axis_tlast
);

  // A stalled result request stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  // A stalled result request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // The input side closes only right after it took a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input closed without an accepted sample");

  // A new result appears only out of a busy computation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while the block was idle");

  // Results never appear straight after a configuration write made while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared after a register write");

endmodule

bind centered_moving_average cma_checker #(
  .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
  .SAMPLE_BITS    (SAMPLE_BITS)
) u_cma_checker (.*);

// ===== tb/centered_moving_average_tb.sv =====
// Self-checking testbench for the centered moving average filter.
// Drives sample blocks over the stream ports, predicts every average and checks it.
// Depends on cma_pkg and centered_moving_average.
`timescale 1ns / 1ps

module centered_moving_average_tb;

  localparam int unsigned SampleW   = cma_pkg::SampleBitsDef;
  localparam int unsigned TdataW    = ((SampleW + 7) / 8) * 8;
  localparam int unsigned StoreLen  = 2 * cma_pkg::MaxHalfWindowDef + 1;
  localparam int unsigned SettleCyc = 100;   // settle time after the owed averages are out
  localparam int unsigned HoldCyc   = 600;   // long output hold-off
  localparam int unsigned WdLimit   = 4000;  // cycles without any request accepted
  localparam int unsigned RandItems = 130;

  // One expected average: value and last-result flag.
  typedef struct packed {
    logic [SampleW-1:0] val;
    logic               lst;
  } avg_t;

  // One directed request; wr writes hw before the sample is sent, pin fixes the result.
  typedef struct {
    bit                 wr;
    bit [2:0]           hw;
    bit [SampleW-1:0]   smp;
    bit                 lst;
    bit                 pin;
    bit [SampleW-1:0]   want;
  } dir_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [cma_pkg::HwBits-1:0] cfg_wdata_i = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [TdataW-1:0]          s_axis_tdata = '0;   // [23:0] sample
  logic                       s_axis_tlast = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [TdataW-1:0]          m_axis_tdata;        // [23:0] filtered_value
  logic                       m_axis_tlast;

  // Local copy of the filter state.
  logic [SampleW-1:0] win_buf [StoreLen];
  int unsigned        half_w = cma_pkg::HwReset;
  int unsigned        n_recv = 0;
  int unsigned        n_pend = 0;

  avg_t        owed_q [$];
  int unsigned n_err = 0;
  int unsigned results_seen = 0;
  int unsigned samples_sent = 0;
  int unsigned blocks_done = 0;
  bit [7:0]    hw_seen = 8'b0000_0010;
  bit          steady = 1'b0;
  logic        hold_req = 1'b0;
  logic        held = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  dir_row_t dir_rows [25] = '{
    // Reset value of the half window: a one-sample block returns itself.
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF},
    '{1'b0, 3'd0, 24'h000000, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'h000001, 1'b1, 1'b0, 24'h0},
    // Zero half window: every sample comes back unchanged.
    '{1'b1, 3'd0, 24'h000000, 1'b0, 1'b1, 24'h000000},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF},
    '{1'b0, 3'd0, 24'hA5A5A5, 1'b1, 1'b1, 24'hA5A5A5},
    // Largest half window with a short block, flushed by its last sample.
    '{1'b1, 3'd7, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b1, 1'b0, 24'h0},
    // Open block that the next register write drops.
    '{1'b0, 3'd0, 24'h123456, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'h654321, 1'b0, 1'b0, 24'h0},
    '{1'b1, 3'd2, 24'h5A5A5A, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'h000000, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'h000001, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'h800000, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'h7FFFFF, 1'b1, 1'b0, 24'h0},
    // Windows of maxima, up to a full one, to stress the sum width.
    '{1'b1, 3'd3, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{1'b0, 3'd0, 24'hFFFFFE, 1'b1, 1'b0, 24'h0}
  };

  centered_moving_average i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Truncated mean of the newest n stored samples.
  function automatic logic [SampleW-1:0] window_mean(input int unsigned n);
    logic [31:0] sum;
    sum = '0;
    for (int unsigned j = 0; j < n; j++) begin
      sum += 32'(win_buf[j]);
    end
    return SampleW'(sum / n);
  endfunction

  // Advances the local filter by one sample and queues the averages it releases.
  task automatic filter_sample(input logic [SampleW-1:0] smp, input logic lst,
                               input bit pin, input logic [SampleW-1:0] want);
    int unsigned span;
    int unsigned cnt;
    span = 2 * half_w + 1;
    for (int j = StoreLen - 1; j > 0; j--) begin
      win_buf[j] = win_buf[j-1];
    end
    win_buf[0] = smp;
    if (n_recv < span) n_recv++;
    if (!lst) begin
      if (n_pend < half_w) begin
        n_pend++;
      end else begin
        owed_q.push_back(avg_t'{pin ? want : window_mean(n_recv), 1'b0});
      end
    end else begin
      // The last sample flushes every average still owed, clipping the window.
      for (int d = n_pend + 1; d > 0; d--) begin
        cnt = d + half_w;
        if (cnt > n_recv) cnt = n_recv;
        owed_q.push_back(avg_t'{pin ? want : window_mean(cnt), d == 1});
      end
      n_recv = 0;
      n_pend = 0;
      blocks_done++;
    end
  endtask

  // Offers one sample with random gaps and returns once the request is accepted.
  task automatic push_sample(input logic [SampleW-1:0] smp, input logic lst);
    while (!steady && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TdataW'(smp);
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_sent++;
  endtask

  // Stops sending until every owed average is out, then lets the divider settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Writes the half window while the block is idle; this opens a new block.
  task automatic set_half(input logic [2:0] hw);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    half_w = hw;
    n_recv = 0;
    n_pend = 0;
    hw_seen[hw] = 1'b1;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    n_err++;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !held) begin
      held <= 1'b1;
      hold_left <= HoldCyc;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // Compares each accepted result with the oldest owed average.
  always @(posedge clk_i) begin : check_results
    avg_t owed;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        owed = owed_q.pop_front();
        if (m_axis_tdata[SampleW-1:0] !== owed.val) begin
          report_mismatch($sformatf("filtered_value %h, expected %h",
                                    m_axis_tdata[SampleW-1:0], owed.val));
        end
        if (m_axis_tlast !== owed.lst) begin
          report_mismatch($sformatf("last_result %b, expected %b", m_axis_tlast, owed.lst));
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request on any port.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WdLimit) begin
      $display("Watchdog: no traffic for %0d cycles, %0d results owed", WdLimit,
               owed_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned rand_sent;
    int unsigned nblk;
    int unsigned blen;
    logic [2:0]  hw;
    bit          broken;
    logic [SampleW-1:0] smp;
    logic        lst;

    for (int j = 0; j < StoreLen; j++) win_buf[j] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (dir_rows[k]) begin
      if (dir_rows[k].wr) set_half(dir_rows[k].hw);
      push_sample(dir_rows[k].smp, dir_rows[k].lst);
      filter_sample(dir_rows[k].smp, dir_rows[k].lst, dir_rows[k].pin, dir_rows[k].want);
    end

    // Random blocks, one half window setting per phase.
    phase = 0;
    rand_sent = 0;
    while (rand_sent < RandItems) begin
      steady = (phase >= 3 && phase <= 5);
      case (phase)
        0:       hw = 3'd7;
        1:       hw = 3'd0;
        2:       hw = 3'd3;
        default: hw = 3'($urandom_range(7));
      endcase
      set_half(hw);
      // Hold the output while a long block streams in so the block backs up.
      if (phase == 2) hold_req <= 1'b1;
      nblk = $urandom_range(1, 3);
      for (int unsigned b = 0; b < nblk; b++) begin
        if (phase == 2 && b == 0) blen = 24;
        else if ($urandom_range(7) == 0) blen = $urandom_range(1, 24);
        else blen = $urandom_range(1, 2 * hw + 3);
        // Now and then the final block stays open and the next write drops it.
        broken = (b == nblk - 1) && ($urandom_range(5) == 0);
        for (int unsigned i = 0; i < blen; i++) begin
          case ($urandom_range(7))
            0:       smp = '0;
            1:       smp = '1;
            default: smp = SampleW'($urandom);
          endcase
          lst = (i == blen - 1) && !broken;
          push_sample(smp, lst);
          filter_sample(smp, lst, 1'b0, '0);
          rand_sent++;
        end
        if ($urandom_range(3) == 0) wait_drained();
      end
      phase++;
    end

    wait_drained();
    $display("Sent %0d samples, closed %0d blocks, checked %0d averages.",
             samples_sent, blocks_done, results_seen);
    $display("Half window settings written (bit n for setting n): %b", hw_seen);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
